>>> sv/trca_pkg.sv
// Shared types, constants and helper functions of the two-channel record averager.
package trca_pkg;

	localparam int BIN_DEPTH   = 4096;
	localparam int ADDR_W      = 12;
	localparam int SAMPLE_W    = 8;
	localparam int SUM_W       = 24;
	localparam int DEN_W       = 24;
	localparam int SCALE_W     = 26;
	localparam int MAG_W       = 25;
	localparam int PROD_W      = SCALE_W + MAG_W;
	localparam int DVD_W       = PROD_W + 2;
	localparam int VOLT_W      = 27;
	localparam int CNT_W       = 6;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_RECORD_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEATS       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SEGMENTS      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ROUND_ROBINS  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_VSCALE        = 3'd4;

	localparam logic [12:0]        MAX_LEN   = 13'd4096;
	localparam logic [8:0]         MAX_CNT   = 9'd256;
	localparam logic [12:0]        RST_LEN   = 13'd1;
	localparam logic [8:0]         RST_CNT   = 9'd1;
	localparam logic [15:0]        RST_VSCALE = 16'd1000;
	localparam logic [9:0]         MV_TO_UV  = 10'd1000;
	localparam logic [SCALE_W-1:0] OUT_LIMIT = 26'd65535000;
	localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(DVD_W - 1);

	typedef struct packed {
		logic take;
		logic sum;
		logic diff;
		logic mul;
		logic load;
		logic step;
		logic emit;
	} trca_cmd_t;

	typedef struct packed {
		logic final_item;
		logic div_last;
	} trca_sts_t;

	function automatic logic [12:0] clamp_len(input logic [12:0] v);
		logic [12:0] r;
		if (v == 13'd0) begin
			r = 13'd1;
		end else if (v > MAX_LEN) begin
			r = MAX_LEN;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [8:0] clamp_cnt(input logic [8:0] v);
		logic [8:0] r;
		if (v == 9'd0) begin
			r = 9'd1;
		end else if (v > MAX_CNT) begin
			r = MAX_CNT;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> sv/trca_ctrl.sv
// Controller state machine of the two-channel record averager.
module trca_ctrl import trca_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  trca_sts_t sts,
	output trca_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SUM  = 3'd1;
	localparam logic [2:0] S_DIFF = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_LOAD = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = sts.final_item ? S_DIFF : S_IDLE;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> sv/trca_datapath.sv
// Datapath of the two-channel record averager: counters, bin memory, scaling and dividers.
module trca_datapath import trca_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic [SAMPLE_W-1:0]      sample_a,
	input  logic [SAMPLE_W-1:0]      sample_b,
	input  trca_cmd_t                cmd,
	output trca_sts_t                sts,
	output logic [ADDR_W-1:0]        bin_index,
	output logic signed [VOLT_W-1:0] volts_a,
	output logic signed [VOLT_W-1:0] volts_b,
	output logic                     last_bin
);

	logic [12:0] record_length_q;
	logic [8:0]  repeats_q;
	logic [12:0] segments_q;
	logic [8:0]  round_robins_q;
	logic [15:0] vscale_q;

	logic [ADDR_W-1:0] sample_q;
	logic [7:0]        repeat_q;
	logic [ADDR_W-1:0] segment_q;
	logic [7:0]        pass_q;
	logic [ADDR_W-1:0] base_q;

	logic [12:0]       rl;
	logic [8:0]        rp;
	logic [12:0]       sg;
	logic [8:0]        rr;
	logic [ADDR_W-1:0] rl_m1;
	logic [7:0]        rp_m1;
	logic [ADDR_W-1:0] sg_m1;
	logic [7:0]        rr_m1;
	logic [ADDR_W-1:0] addr;
	logic              wrap_sample;
	logic              wrap_repeat;
	logic              wrap_seg;
	logic              wrap_pass;
	logic              cfg_known;

	logic [2*SUM_W-1:0] sum_mem_q [0:BIN_DEPTH-1];

	logic [SAMPLE_W-1:0] smp_s1 [2];
	logic [2*SUM_W-1:0]  rd_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                first_s1;
	logic                final_s1;
	logic                last_s1;

	logic [SUM_W-1:0]    new_sum [2];
	logic [16:0]         n_items;
	logic [DEN_W:0]      den_full;
	logic [SCALE_W-1:0]  scale;
	logic [SUM_W-1:0]    sum_s2 [2];
	logic [DEN_W-1:0]    den_s2;
	logic [SCALE_W-1:0]  scale_s2;

	logic [SCALE_W-1:0]  diff [2];
	logic [MAG_W-1:0]    mag_s3 [2];
	logic                neg_s3 [2];

	logic [PROD_W-1:0]   prod [2];
	logic [PROD_W-1:0]   prod_s4 [2];

	logic [MAG_W-1:0]    div_e;
	logic [DVD_W-1:0]    dvd_q [2];
	logic [MAG_W-1:0]    rem_q [2];
	logic [CNT_W-1:0]    cnt_q;
	logic [MAG_W:0]      rem_sh [2];
	logic                ge [2];

	logic [SCALE_W-1:0]  qmag [2];
	logic [VOLT_W-1:0]   volt [2];

	assign rl    = clamp_len(record_length_q);
	assign rp    = clamp_cnt(repeats_q);
	assign sg    = clamp_len(segments_q);
	assign rr    = clamp_cnt(round_robins_q);
	assign rl_m1 = ADDR_W'(rl - 13'd1);
	assign rp_m1 = 8'(rp - 9'd1);
	assign sg_m1 = ADDR_W'(sg - 13'd1);
	assign rr_m1 = 8'(rr - 9'd1);
	assign addr  = base_q + sample_q;

	assign wrap_sample = (sample_q == rl_m1);
	assign wrap_repeat = (repeat_q == rp_m1);
	assign wrap_seg    = (segment_q == sg_m1);
	assign wrap_pass   = (pass_q == rr_m1);

	always_comb begin
		unique case (cfg_index) inside
			REG_RECORD_LENGTH, REG_REPEATS, REG_SEGMENTS, REG_ROUND_ROBINS,
			REG_VSCALE: begin
				cfg_known = 1'b1;
			end
			default: begin
				cfg_known = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_length_q <= RST_LEN;
			repeats_q       <= RST_CNT;
			segments_q      <= RST_LEN;
			round_robins_q  <= RST_CNT;
			vscale_q        <= RST_VSCALE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RECORD_LENGTH: record_length_q <= cfg_data[12:0];
				REG_REPEATS:       repeats_q       <= cfg_data[8:0];
				REG_SEGMENTS:      segments_q      <= cfg_data[12:0];
				REG_ROUND_ROBINS:  round_robins_q  <= cfg_data[8:0];
				REG_VSCALE:        vscale_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q  <= '0;
			repeat_q  <= '0;
			segment_q <= '0;
			pass_q    <= '0;
			base_q    <= '0;
		end else if (cfg_write && cfg_known) begin
			sample_q  <= '0;
			repeat_q  <= '0;
			segment_q <= '0;
			pass_q    <= '0;
			base_q    <= '0;
		end else if (cmd.take) begin
			if (wrap_sample) begin
				sample_q <= '0;
				if (wrap_repeat) begin
					repeat_q <= '0;
					if (wrap_seg) begin
						segment_q <= '0;
						base_q    <= '0;
						pass_q    <= wrap_pass ? 8'd0 : pass_q + 8'd1;
					end else begin
						segment_q <= segment_q + ADDR_W'(1);
						base_q    <= base_q + rl[ADDR_W-1:0];
					end
				end else begin
					repeat_q <= repeat_q + 8'd1;
				end
			end else begin
				sample_q <= sample_q + ADDR_W'(1);
			end
		end
	end

	// bin memory: read on accept, written back in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rd_s1 <= sum_mem_q[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_mem_q[addr_s1] <= {new_sum[1], new_sum[0]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			smp_s1[0] <= sample_a;
			smp_s1[1] <= sample_b;
			addr_s1   <= addr;
			first_s1  <= (repeat_q == 8'd0) && (pass_q == 8'd0);
			final_s1  <= wrap_repeat && wrap_pass;
			last_s1   <= wrap_sample && wrap_seg;
		end
	end

	assign n_items  = 17'(rp) * 17'(rr);
	assign den_full = {n_items, 8'd0} - {8'd0, n_items};
	assign scale    = SCALE_W'(vscale_q) * SCALE_W'(MV_TO_UV);
	assign div_e    = {den_s2, 1'b0};

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			new_sum[i] = first_s1 ? SUM_W'(smp_s1[i])
				: rd_s1[i*SUM_W +: SUM_W] + SUM_W'(smp_s1[i]);
			diff[i]    = {1'b0, sum_s2[i], 1'b0} - {2'b00, den_s2};
			prod[i]    = PROD_W'(scale_s2) * PROD_W'(mag_s3[i]);
			rem_sh[i]  = {rem_q[i], dvd_q[i][DVD_W-1]};
			ge[i]      = (rem_sh[i] >= {1'b0, div_e});
			qmag[i]    = (dvd_q[i] > DVD_W'(OUT_LIMIT)) ? OUT_LIMIT : dvd_q[i][SCALE_W-1:0];
			volt[i]    = neg_s3[i] ? VOLT_W'(0) - {1'b0, qmag[i]} : {1'b0, qmag[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			sum_s2[0] <= new_sum[0];
			sum_s2[1] <= new_sum[1];
			den_s2    <= den_full[DEN_W-1:0];
			scale_s2  <= scale;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			for (int i = 0; i < 2; i++) begin
				neg_s3[i] <= diff[i][SCALE_W-1];
				mag_s3[i] <= diff[i][SCALE_W-1] ? MAG_W'(SCALE_W'(0) - diff[i])
					: diff[i][MAG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s4[0] <= prod[0];
			prod_s4[1] <= prod[1];
		end
	end

	// restoring divide, one quotient bit a cycle per channel
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 2; i++) begin
				dvd_q[i] <= {1'b0, prod_s4[i], 1'b0} + DVD_W'(den_s2);
				rem_q[i] <= '0;
			end
		end else if (cmd.step) begin
			for (int i = 0; i < 2; i++) begin
				dvd_q[i] <= {dvd_q[i][DVD_W-2:0], ge[i]};
				rem_q[i] <= ge[i] ? MAG_W'(rem_sh[i] - {1'b0, div_e}) : rem_sh[i][MAG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			bin_index <= addr_s1;
			volts_a   <= volt[0];
			volts_b   <= volt[1];
			last_bin  <= last_s1;
		end
	end

	assign sts.final_item = final_s1;
	assign sts.div_last   = (cnt_q == DIV_LAST);

endmodule

>>> sv/two_channel_record_averager.sv
// Top level of the two-channel record averager.
// Usage: write record_length, repeats, segments, round_robins and vertical_scale_mv on
// the cfg_write / cfg_index / cfg_data port while the block is idle; any write to a
// known index restarts the buffer position. Sample pairs enter on the in_ channel
// (in_valid, in_stall, sample_a, sample_b) in buffer order: sample, repeat, segment,
// round robin. Each word is summed into its bin in a 4096-entry memory.
// A word that does not close its bin passes through a memory read, then write back,
// and gives no result. The word that closes a bin goes through write back, offset,
// one multiply, divider load, 53 divider steps of one quotient bit each, then the
// result word is loaded into the output register. Results leave on the out_ channel
// (out_valid, out_stall, bin_index, volts_a, volts_b, last_bin); while out_stall holds
// a result the block still takes new words until a further result is ready. Reset
// clears the position counters and the registers to their defaults; bin memory
// contents are not cleared and need no clearing pass.
module two_channel_record_averager import trca_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [SAMPLE_W-1:0]      sample_a,
	input  logic [SAMPLE_W-1:0]      sample_b,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ADDR_W-1:0]        bin_index,
	output logic signed [VOLT_W-1:0] volts_a,
	output logic signed [VOLT_W-1:0] volts_b,
	output logic                     last_bin
);

	trca_cmd_t cmd;
	trca_sts_t sts;

	trca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	trca_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_a  (sample_a),
		.sample_b  (sample_b),
		.cmd       (cmd),
		.sts       (sts),
		.bin_index (bin_index),
		.volts_a   (volts_a),
		.volts_b   (volts_b),
		.last_bin  (last_bin)
	);

endmodule

>>> sim/two_channel_record_averager_tb.sv
// Self-checking testbench for the two-channel record averager: bin averages predicted per word.
module two_channel_record_averager_tb;
	import trca_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int           HALF_PERIOD   = 2;
	localparam int           RESET_CYCLES  = 10;
	localparam int           RAND_WORDS    = 970;
	localparam int           HOLD_CYCLES   = 300;
	localparam int           SETTLE_CYCLES = 16;
	localparam int           QUIET_LIMIT   = 4000;
	localparam int unsigned  FULL_CODE     = (1 << SAMPLE_W) - 1;
	localparam int unsigned  LEN_MAX       = 4096;
	localparam int unsigned  CNT_MAX       = 256;
	localparam longint       UV_PER_MV     = 1000;
	localparam longint       VOLT_MAX      = 65535000;

	typedef struct {
		logic [ADDR_W-1:0]        bin;
		logic signed [VOLT_W-1:0] va;
		logic signed [VOLT_W-1:0] vb;
		logic                     last;
	} bin_average_t;

	class averager_tracker;
		logic [12:0]      len_reg;
		logic [8:0]       rep_reg;
		logic [12:0]      seg_reg;
		logic [8:0]       rr_reg;
		logic [15:0]      mv_reg;
		int unsigned      smp, rep, seg, rnd;
		logic [SUM_W-1:0] acc_a [BIN_DEPTH];
		logic [SUM_W-1:0] acc_b [BIN_DEPTH];
		bin_average_t     due[$];
		int               errors, words, averages, saturated;

		function new();
			len_reg = 13'd1;
			rep_reg = 9'd1;
			seg_reg = 13'd1;
			rr_reg  = 9'd1;
			mv_reg  = 16'd1000;
			restart();
			foreach (acc_a[i]) begin
				acc_a[i] = '0;
				acc_b[i] = '0;
			end
			errors = 0;
			words = 0;
			averages = 0;
			saturated = 0;
		endfunction

		function void restart();
			smp = 0;
			rep = 0;
			seg = 0;
			rnd = 0;
		endfunction

		function int unsigned lim(int unsigned v, int unsigned hi);
			if (v < 1) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_RECORD_LENGTH: len_reg = d[12:0];
				REG_REPEATS:       rep_reg = d[8:0];
				REG_SEGMENTS:      seg_reg = d[12:0];
				REG_ROUND_ROBINS:  rr_reg  = d[8:0];
				REG_VSCALE:        mv_reg  = d;
				default: return;
			endcase
			restart();
		endfunction

		function logic [VOLT_W-1:0] microvolts(logic [SUM_W-1:0] s, int unsigned n);
			longint          den, diff, num;
			longint unsigned mag, q;
			logic [63:0]     r;
			den  = longint'(FULL_CODE) * longint'(n);
			diff = 2 * longint'(s) - den;
			num  = longint'(mv_reg) * UV_PER_MV * diff;
			mag  = (num < 0) ? longint'(-num) : num;
			q    = (2 * mag + den) / (2 * den);
			if (q > VOLT_MAX) begin
				q = VOLT_MAX;
				saturated++;
			end
			r = (num < 0) ? -q : q;
			return r[VOLT_W-1:0];
		endfunction

		function void take_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
			int unsigned  rl, rp, sg, rr, addr;
			bit           opens, closes;
			bin_average_t r;
			rl = lim(len_reg, LEN_MAX);
			rp = lim(rep_reg, CNT_MAX);
			sg = lim(seg_reg, LEN_MAX);
			rr = lim(rr_reg, CNT_MAX);
			addr = (smp + seg * rl) % BIN_DEPTH;
			opens  = (rep == 0) && (rnd == 0);
			closes = (rep == rp - 1) && (rnd == rr - 1);
			words++;
			if (opens) begin
				acc_a[addr] = SUM_W'(a);
				acc_b[addr] = SUM_W'(b);
			end else begin
				acc_a[addr] = acc_a[addr] + SUM_W'(a);
				acc_b[addr] = acc_b[addr] + SUM_W'(b);
			end
			if (closes) begin
				r.bin  = addr[ADDR_W-1:0];
				r.va   = microvolts(acc_a[addr], rp * rr);
				r.vb   = microvolts(acc_b[addr], rp * rr);
				r.last = (smp == rl - 1) && (seg == sg - 1);
				due.push_back(r);
			end
			smp++;
			if (smp >= rl) begin
				smp = 0;
				rep++;
				if (rep >= rp) begin
					rep = 0;
					seg++;
					if (seg >= sg) begin
						seg = 0;
						rnd++;
						if (rnd >= rr) rnd = 0;
					end
				end
			end
		endfunction

		function void match_average(logic [ADDR_W-1:0] bin, logic signed [VOLT_W-1:0] va,
				logic signed [VOLT_W-1:0] vb, logic last);
			bin_average_t e;
			if (due.size() == 0) begin
				$display("%0t: unexpected result bin_index %0d volts_a %0d volts_b %0d",
					$time, bin, va, vb);
				errors++;
				return;
			end
			e = due.pop_front();
			averages++;
			if (bin !== e.bin) begin
				$display("%0t: bin_index expected %0d actual %0d", $time, e.bin, bin);
				errors++;
			end
			if (va !== e.va) begin
				$display("%0t: volts_a bin %0d expected %0d actual %0d", $time, e.bin, e.va, va);
				errors++;
			end
			if (vb !== e.vb) begin
				$display("%0t: volts_b bin %0d expected %0d actual %0d", $time, e.bin, e.vb, vb);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last_bin bin %0d expected %0b actual %0b", $time, e.bin, e.last,
					last);
				errors++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_write;
	logic [CFG_INDEX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [SAMPLE_W-1:0]      sample_a;
	logic [SAMPLE_W-1:0]      sample_b;
	logic                     out_valid;
	logic                     out_stall;
	logic [ADDR_W-1:0]        bin_index;
	logic signed [VOLT_W-1:0] volts_a;
	logic signed [VOLT_W-1:0] volts_b;
	logic                     last_bin;

	averager_tracker trk = new();
	bit idle_in;
	bit idle_out;
	bit hold_req;
	int quiet;
	int settings_done;
	int rand_words;

	two_channel_record_averager DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_a  (sample_a),
		.sample_b  (sample_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bin_index (bin_index),
		.volts_a   (volts_a),
		.volts_b   (volts_b),
		.last_bin  (last_bin)
	);

	initial begin
		clk = 1'b0;
		forever #(HALF_PERIOD) clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall === 1'b0)
				trk.match_average(bin_index, volts_a, volts_b, last_bin);
			if (in_valid === 1'b1 && in_stall === 1'b0)
				trk.take_pair(sample_a, sample_b);
			if (cfg_write === 1'b1)
				trk.write_register(cfg_index, cfg_data);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: timeout with %0d results outstanding", $time, trk.due.size());
				$display("two_channel_record_averager_tb NOT OK");
				$finish;
			end
		end
	end

	// Result side: random stall per word, one long hold-off on request.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			n = idle_out ? $urandom_range(0, 5) : 0;
			if (n > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	task automatic send_word(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
		int gap;
		gap = idle_in ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample_a <= a;
		sample_b <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic feed(input int count, input int lo, input int hi);
		repeat (count) send_word(SAMPLE_W'($urandom_range(lo, hi)),
			SAMPLE_W'($urandom_range(lo, hi)));
	endtask

	// Drop valid, wait out every result, then let the pipeline settle with no new words.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (trk.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	task automatic release_cfg();
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic load_settings(input logic [CFG_DATA_W-1:0] len, input logic [CFG_DATA_W-1:0] reps,
			input logic [CFG_DATA_W-1:0] segs, input logic [CFG_DATA_W-1:0] rounds,
			input logic [CFG_DATA_W-1:0] mv);
		put_reg(REG_RECORD_LENGTH, len);
		put_reg(REG_REPEATS, reps);
		put_reg(REG_SEGMENTS, segs);
		put_reg(REG_ROUND_ROBINS, rounds);
		put_reg(REG_VSCALE, mv);
		release_cfg();
		settings_done++;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_count(input int hi);
		if ($urandom_range(0, 9) == 0) return '0;
		return CFG_DATA_W'($urandom_range(1, hi));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'd1;
			2: return '1;
			default: return CFG_DATA_W'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int phase;
		int len;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		sample_a  = '0;
		sample_b  = '0;
		idle_in   = 1'b1;
		idle_out  = 1'b1;
		hold_req  = 1'b0;
		quiet = 0;
		settings_done = 0;
		rand_words = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: one word per bin, full-scale codes
		send_word(8'd0, 8'd255);
		send_word(8'd255, 8'd0);
		send_word(8'd128, 8'd127);
		send_word(8'h55, 8'hAA);
		send_word(8'hAA, 8'h55);
		drain();

		// zero registers act as one, largest scale
		load_settings('0, '0, '0, '0, '1);
		send_word(8'd0, 8'd255);
		send_word(8'd255, 8'd0);
		drain();

		// zero scale gives zero volts
		load_settings(16'd1, 16'd2, 16'd2, 16'd1, '0);
		feed(4, 0, 255);
		drain();

		// registers above range clamp to the maximum
		idle_out = 1'b0;
		load_settings('1, '1, '1, '1, '1);
		feed(3, 0, 255);
		drain();

		// spare indexes must not restart the buffer position
		idle_out = 1'b1;
		load_settings(16'd3, 16'd1, 16'd1, 16'd2, 16'd1000);
		feed(4, 0, 255);
		drain();
		for (int i = int'(REG_VSCALE) + 1; i < (1 << CFG_INDEX_W); i++)
			put_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom_range(0, 65535)));
		release_cfg();
		feed(2, 0, 255);
		drain();

		// extremes of the count and length registers
		load_settings(16'd1, 16'd256, 16'd1, 16'd1, pick_scale());
		feed(256, 0, 255);
		drain();
		load_settings(16'd1, 16'd1, 16'd1, 16'd256, pick_scale());
		feed(256, 0, 255);
		drain();
		load_settings(16'd4096, 16'd1, 16'd1, 16'd1, pick_scale());
		feed(24, 0, 255);
		drain();
		load_settings(16'd1, 16'd1, 16'd4096, 16'd1, pick_scale());
		feed(24, 0, 255);
		drain();

		phase = 0;
		while (rand_words < RAND_WORDS) begin
			idle_in  = $urandom_range(0, 3) != 0;
			idle_out = $urandom_range(0, 3) != 0;
			len = $urandom_range(16, 160);
			if (phase == 1) begin
				idle_in = 1'b0;
				load_settings(16'd4, 16'd1, 16'd2, 16'd1, pick_scale());
				hold_req = 1'b1;
				len = 120;
			end else if (phase == 3) begin
				// 32 words per bin with a scale of 51 lands exactly on halves
				load_settings(16'd2, 16'd4, 16'd1, 16'd8, 16'd51);
				len = 256;
			end else begin
				load_settings(pick_count(8), pick_count(4), pick_count(4), pick_count(4),
					pick_scale());
			end
			feed(len, 0, 255);
			rand_words += len;
			drain();
			phase++;
		end

		$display("Covered %0d sample pairs and %0d bin averages over %0d register settings,",
			trk.words, trk.averages, settings_done);
		$display("with clamped, zero-scale and spare-index writes; %0d values saturated.",
			trk.saturated);
		if (trk.errors == 0 && trk.due.size() == 0) begin
			$display("two_channel_record_averager_tb OK");
		end else begin
			$display("two_channel_record_averager_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/trca_pkg.sv
sv/trca_ctrl.sv
sv/trca_datapath.sv
sv/two_channel_record_averager.sv
sim/two_channel_record_averager_tb.sv
